// File: hw/rtl/vqt_pkg.sv
// ----------------------------------------------------------------------------
// vqt_pkg: shared types and constants for the vertex transform
// Field widths, register codes and fixed-point constants used by the
// transform pipeline and its port checker.
// ----------------------------------------------------------------------------
package vqt_pkg;

  localparam int CoordW   = 32;               // Q16.16 coordinate
  localparam int QuatW    = 16;               // Q2.14 quaternion component
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int DataW    = 3 * CoordW;       // x, y, z packed in one beat
  localparam int UserW    = 1;

  localparam int RotW     = 34;               // rotation matrix entry, Q.28
  localparam int HalfW    = 16;               // upper half of a coordinate
  localparam int ProdW    = 2 * CoordW;       // scale product, Q32.32
  localparam int ProdHiW  = RotW + HalfW;     // r * hi
  localparam int ProdLoW  = RotW + HalfW + 1; // r * lo, lo zero-extended
  localparam int SumAW    = ProdHiW + 2;
  localparam int SumBW    = ProdLoW + 2;
  localparam int AccW     = SumBW + 1;
  localparam int ResW     = AccW - 12 + 2;    // rounded value plus translation
  localparam int SatInW   = 48;               // input width of the saturator

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [QuatW-1:0]  quat_t;
  typedef logic signed [RotW-1:0]   rot_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_POS_Z   = 3'd2,
    REG_ROT     = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_SCALE_Z = 3'd6
  } cfg_reg_t;

  localparam coord_t               PosReset   = '0;
  localparam coord_t               ScaleReset = 32'sd65536;
  localparam logic [CfgDataW-1:0]  RotReset   = 64'd16384;   // identity
  localparam rot_t                 RotOne     = 34'sd268435456;

  localparam logic signed [SatInW-1:0] SatHi = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SatInW-1:0] SatLo = ~SatHi;

endpackage

// File: hw/rtl/vertex_quaternion_transform.sv
// Throughput: one beat per cycle while the output is not stalled, set by the
// seven-stage pipeline (input, scale multiply, round/saturate, matrix
// multiply, sums, rounding, translate/saturate).
// Reset empties the pipeline and loads unit scale, zero translation and the
// identity rotation; the rotation matrix follows a register write through
// the product and matrix registers.
// ----------------------------------------------------------------------------
// vertex_quaternion_transform: scale, quaternion rotation and translation
// Streams Q16.16 vertices through a saturating fixed-point transform; the
// quaternion is expanded into a registered rotation matrix.
// ----------------------------------------------------------------------------
module vertex_quaternion_transform (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vqt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vqt_pkg::CfgDataW-1:0]  cfg_data,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vqt_pkg::DataW-1:0]     s_tdata,   // in_x, in_y, in_z
  input  logic [vqt_pkg::UserW-1:0]     s_tuser,   // is_point
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vqt_pkg::DataW-1:0]     m_tdata,   // out_x, out_y, out_z
  output logic [vqt_pkg::UserW-1:0]     m_tuser    // overflow
);
  import vqt_pkg::*;

  typedef struct packed {
    coord_t val;
    logic   ovf;
  } sat_t;

  function automatic sat_t sat_coord(input logic signed [SatInW-1:0] v);
    sat_t r;
    if (v > SatHi) begin
      r.val = SatHi[CoordW-1:0];
      r.ovf = 1'b1;
    end else if (v < SatLo) begin
      r.val = SatLo[CoordW-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[CoordW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  coord_t                pos   [3];
  coord_t                scale [3];
  logic [CfgDataW-1:0]   rot_packed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0]     <= PosReset;
      pos[1]     <= PosReset;
      pos[2]     <= PosReset;
      scale[0]   <= ScaleReset;
      scale[1]   <= ScaleReset;
      scale[2]   <= ScaleReset;
      rot_packed <= RotReset;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_X:   pos[0]     <= cfg_data[CoordW-1:0];
        REG_POS_Y:   pos[1]     <= cfg_data[CoordW-1:0];
        REG_POS_Z:   pos[2]     <= cfg_data[CoordW-1:0];
        REG_ROT:     rot_packed <= cfg_data;
        REG_SCALE_X: scale[0]   <= cfg_data[CoordW-1:0];
        REG_SCALE_Y: scale[1]   <= cfg_data[CoordW-1:0];
        REG_SCALE_Z: scale[2]   <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- quaternion to rotation matrix ----------------
  quat_t qw, qx, qy, qz;
  assign qw = rot_packed[15:0];
  assign qx = rot_packed[31:16];
  assign qy = rot_packed[47:32];
  assign qz = rot_packed[63:48];

  coord_t qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;
  rot_t   rm [3][3];

  always_ff @(posedge clk) begin
    qxx <= CoordW'(qx) * CoordW'(qx);
    qyy <= CoordW'(qy) * CoordW'(qy);
    qzz <= CoordW'(qz) * CoordW'(qz);
    qxy <= CoordW'(qx) * CoordW'(qy);
    qxz <= CoordW'(qx) * CoordW'(qz);
    qyz <= CoordW'(qy) * CoordW'(qz);
    qwx <= CoordW'(qw) * CoordW'(qx);
    qwy <= CoordW'(qw) * CoordW'(qy);
    qwz <= CoordW'(qw) * CoordW'(qz);
  end

  always_ff @(posedge clk) begin
    rm[0][0] <= RotOne - ((rot_t'(qyy) + rot_t'(qzz)) <<< 1);
    rm[0][1] <= (rot_t'(qxy) - rot_t'(qwz)) <<< 1;
    rm[0][2] <= (rot_t'(qxz) + rot_t'(qwy)) <<< 1;
    rm[1][0] <= (rot_t'(qxy) + rot_t'(qwz)) <<< 1;
    rm[1][1] <= RotOne - ((rot_t'(qxx) + rot_t'(qzz)) <<< 1);
    rm[1][2] <= (rot_t'(qyz) - rot_t'(qwx)) <<< 1;
    rm[2][0] <= (rot_t'(qxz) - rot_t'(qwy)) <<< 1;
    rm[2][1] <= (rot_t'(qyz) + rot_t'(qwx)) <<< 1;
    rm[2][2] <= RotOne - ((rot_t'(qxx) + rot_t'(qyy)) <<< 1);
  end

  // ---------------- pipeline control ----------------
  logic [7:1] vld;
  logic [7:1] en;

  always_comb begin
    en[7] = !vld[7] || m_tready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  coord_t in1 [3];
  logic   pt1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      in1[0] <= s_tdata[CoordW-1:0];
      in1[1] <= s_tdata[2*CoordW-1:CoordW];
      in1[2] <= s_tdata[3*CoordW-1:2*CoordW];
      pt1    <= s_tuser[0];
    end
  end

  // ---------------- stage 2: scale products ----------------
  logic signed [ProdW-1:0] p2 [3];
  logic                    pt2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) p2[i] <= ProdW'(scale[i]) * ProdW'(in1[i]);
      pt2 <= pt1;
    end
  end

  // ---------------- stage 3: round to Q16.16 and saturate ----------------
  logic signed [ProdW-1:0] p2r [3];
  sat_t                    s_sat [3];
  coord_t                  s3 [3];
  logic                    ovf3, pt3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2r[i]   = p2[i] + ProdW'(32768);
      s_sat[i] = sat_coord(p2r[i][ProdW-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) s3[i] <= s_sat[i].val;
      ovf3 <= s_sat[0].ovf | s_sat[1].ovf | s_sat[2].ovf;
      pt3  <= pt2;
    end
  end

  // ---------------- stage 4: matrix times split vector ----------------
  logic signed [HalfW-1:0]   hi [3];
  logic signed [HalfW:0]     lo [3];
  logic signed [ProdHiW-1:0] ph4 [3][3];
  logic signed [ProdLoW-1:0] pl4 [3][3];
  logic                      ovf4, pt4;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hi[j] = s3[j][CoordW-1:HalfW];
      lo[j] = {1'b0, s3[j][HalfW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph4[i][j] <= ProdHiW'(rm[i][j]) * ProdHiW'(hi[j]);
          pl4[i][j] <= ProdLoW'(rm[i][j]) * ProdLoW'(lo[j]);
        end
      end
      ovf4 <= ovf3;
      pt4  <= pt3;
    end
  end

  // ---------------- stage 5: row sums ----------------
  logic signed [SumAW-1:0] a5 [3];
  logic signed [SumBW-1:0] b5 [3];
  logic                    ovf5, pt5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        a5[i] <= SumAW'(ph4[i][0]) + SumAW'(ph4[i][1]) + SumAW'(ph4[i][2]);
        b5[i] <= SumBW'(pl4[i][0]) + SumBW'(pl4[i][1]) + SumBW'(pl4[i][2]);
      end
      ovf5 <= ovf4;
      pt5  <= pt4;
    end
  end

  // ---------------- stage 6: merge halves, add rounding half ----------------
  logic signed [SumBW-17:0] b5s [3];
  logic signed [AccW-1:0]   t6 [3];
  logic                     ovf6, pt6;

  always_comb begin
    for (int i = 0; i < 3; i++) b5s[i] = b5[i][SumBW-1:16];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        t6[i] <= AccW'(a5[i]) + AccW'(b5s[i]) + AccW'(2048);
      end
      ovf6 <= ovf5;
      pt6  <= pt5;
    end
  end

  // ---------------- stage 7: translate, saturate, output ----------------
  logic signed [AccW-13:0] t6s [3];
  logic signed [ResW-1:0]  res7 [3];
  sat_t                    o_sat [3];
  coord_t                  out_c [3];
  logic                    oflag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t6s[i]   = t6[i][AccW-1:12];
      res7[i]  = ResW'(t6s[i]) + (pt6 ? ResW'(pos[i]) : ResW'(0));
      o_sat[i] = sat_coord(SatInW'(res7[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) out_c[i] <= o_sat[i].val;
      oflag <= ovf6 | o_sat[0].ovf | o_sat[1].ovf | o_sat[2].ovf;
    end
  end

  assign m_tvalid   = vld[7];
  assign m_tdata    = {out_c[2], out_c[1], out_c[0]};
  assign m_tuser[0] = oflag;

endmodule

// File: hw/rtl/vqt_checker.sv
// ----------------------------------------------------------------------------
// vqt_checker: port-level checks for the vertex transform
// Watches the stream ports for reset, stall and backpressure behavior.
// ----------------------------------------------------------------------------
module vqt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [vqt_pkg::DataW-1:0]  m_tdata,
  input logic [vqt_pkg::UserW-1:0]  m_tuser
);
  import vqt_pkg::*;

  // reset drains the whole pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // input backpressure only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input not ready while pipeline can advance");

  // input handshake never stalls on an empty output side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind vertex_quaternion_transform vqt_checker u_vqt_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: vertex_quaternion_transform stream check
// Drives Q16.16 vertices and directions through the transform under several
// scale / rotation / translation settings and random handshake pressure, and
// compares every output beat with a bit-exact fixed-point transform computed
// here.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vqt_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 210;
  localparam int RandPhases    = 8;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   is_point;
    logic   hold;       // wait for all results before sending this one
  } vtx_in_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   ovf;
  } vtx_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
  } reg_write_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DataW-1:0]    s_tdata = '0;   // in_x, in_y, in_z
  logic [UserW-1:0]    s_tuser = '0;   // is_point
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DataW-1:0]    m_tdata;        // out_x, out_y, out_z
  logic [UserW-1:0]    m_tuser;        // overflow

  // transform settings as the block should hold them
  coord_t              trans [3] = '{PosReset, PosReset, PosReset};
  coord_t              scl [3] = '{ScaleReset, ScaleReset, ScaleReset};
  logic [CfgDataW-1:0] quat = RotReset;

  vtx_in_t    vertex_queue [$];
  vtx_out_t   predicted_vertices [$];
  reg_write_t reg_writes [$];
  vtx_in_t    cur_vtx;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  bit         timed_out = 1'b0;

  vertex_quaternion_transform u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v, inout bit sat);
    if (v > longint'(SatHi)) begin
      sat = 1'b1;
      return longint'(SatHi);
    end
    if (v < longint'(SatLo)) begin
      sat = 1'b1;
      return longint'(SatLo);
    end
    return v;
  endfunction

  // scale, rotate by the expanded quaternion matrix (Q.28), translate points
  function automatic vtx_out_t transform_vertex(input vtx_in_t v);
    longint q [4];
    longint hi [3];
    longint lo [3];
    longint rm [3][3];
    longint sv, acc_hi, acc_lo, val, one;
    coord_t vin [3];
    coord_t res [3];
    vtx_out_t r;
    bit sat;
    sat = 1'b0;
    one = longint'(RotOne);
    vin[0] = v.x;
    vin[1] = v.y;
    vin[2] = v.z;
    for (int i = 0; i < 3; i++) begin
      sv = clamp32((longint'(scl[i]) * longint'(vin[i]) + 32768) >>> 16, sat);
      hi[i] = sv >>> 16;
      lo[i] = sv - (hi[i] <<< 16);
    end
    // q[0..3] = w, x, y, z
    for (int k = 0; k < 4; k++) q[k] = longint'($signed(quat[16*k +: 16]));
    rm[0][0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
    rm[0][1] = 2 * (q[1] * q[2] - q[0] * q[3]);
    rm[0][2] = 2 * (q[1] * q[3] + q[0] * q[2]);
    rm[1][0] = 2 * (q[1] * q[2] + q[0] * q[3]);
    rm[1][1] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
    rm[1][2] = 2 * (q[2] * q[3] - q[0] * q[1]);
    rm[2][0] = 2 * (q[1] * q[3] - q[0] * q[2]);
    rm[2][1] = 2 * (q[2] * q[3] + q[0] * q[1]);
    rm[2][2] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
    for (int i = 0; i < 3; i++) begin
      acc_hi = 0;
      acc_lo = 0;
      for (int j = 0; j < 3; j++) begin
        acc_hi += rm[i][j] * hi[j];
        acc_lo += rm[i][j] * lo[j];
      end
      val = (acc_hi + (acc_lo >>> 16) + 2048) >>> 12;
      if (v.is_point) val += longint'(trans[i]);
      res[i] = coord_t'(clamp32(val, sat));
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    r.ovf = sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      6, 7, 8: return $urandom();
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // random axis and angle, Q2.14 components
  function automatic logic [63:0] unit_quat();
    real ang, ax, ay, az, nrm, sh;
    logic [15:0] qw, qx, qy, qz;
    ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    ax = $urandom_range(0, 2000) / 1000.0 - 1.0;
    ay = $urandom_range(0, 2000) / 1000.0 - 1.0;
    az = $urandom_range(0, 2000) / 1000.0 - 1.0;
    nrm = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-6;
    sh = $sin(ang / 2.0) / nrm;
    qw = 16'($rtoi(16384.0 * $cos(ang / 2.0)));
    qx = 16'($rtoi(16384.0 * sh * ax));
    qy = 16'($rtoi(16384.0 * sh * ay));
    qz = 16'($rtoi(16384.0 * sh * az));
    return {qz, qy, qx, qw};
  endfunction

  task automatic add_vertex(input coord_t x, input coord_t y, input coord_t z,
                            input logic pt);
    vertex_queue.push_back({x, y, z, pt, 1'b0});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (vertex_queue.size() != 0 || s_tvalid || predicted_vertices.size() != 0)
      @(negedge clk);
  endtask

  // writes every queued register once the pipeline has emptied
  task automatic program_regs();
    reg_write_t wr;
    wait_idle();
    repeat (8) @(posedge clk);
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.val;
      do @(posedge clk); while (!cfg_ready);
      case (wr.idx)
        REG_POS_X:   trans[0] = wr.val[31:0];
        REG_POS_Y:   trans[1] = wr.val[31:0];
        REG_POS_Z:   trans[2] = wr.val[31:0];
        REG_ROT:     quat = wr.val;
        REG_SCALE_X: scl[0] = wr.val[31:0];
        REG_SCALE_Y: scl[1] = wr.val[31:0];
        REG_SCALE_Z: scl[2] = wr.val[31:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    // matrix is rebuilt through the product and matrix registers after the rotation write
    repeat (4) @(posedge clk);
  endtask

  // mode 0: plausible transforms, 1: fully random, 2: extreme corners
  task automatic queue_transform(input int mode);
    logic [CfgDataW-1:0] pv, sv, rv;
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: begin
          pv = {32'h0, 32'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000)};
          sv = {32'h0, 32'($urandom_range(0, 32'h0004_0000) - 32'h0001_0000)};
        end
        1: begin
          pv = {$urandom(), $urandom()};
          sv = {$urandom(), $urandom()};
        end
        default: begin
          pv = {32'h0, pick_extreme()};
          sv = {32'h0, pick_extreme()};
        end
      endcase
      reg_writes.push_back({3'(REG_POS_X + k), pv});
      reg_writes.push_back({3'(REG_SCALE_X + k), sv});
    end
    case (mode)
      0: rv = unit_quat();
      1: rv = {$urandom(), $urandom()};
      default: begin
        case ($urandom_range(3))
          0: rv = RotReset;
          1: rv = 64'h8000_8000_8000_8000;
          2: rv = 64'h7FFF_7FFF_7FFF_7FFF;
          default: rv = {$urandom(), $urandom()};
        endcase
      end
    endcase
    reg_writes.push_back({REG_ROT, rv});
  endtask

  // sender: one beat per handshake, expectation computed on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predicted_vertices.push_back(transform_vertex(cur_vtx));
      if (vertex_queue.size() != 0
          && !(vertex_queue[0].hold && predicted_vertices.size() != 0)
          && $urandom_range(99) >= send_idle_pct) begin
        cur_vtx = vertex_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {cur_vtx.z, cur_vtx.y, cur_vtx.x};
        s_tuser  <= cur_vtx.is_point;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    vtx_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_vertices.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: data=%h ovf=%b", m_tdata, m_tuser);
        end else begin
          want = predicted_vertices.pop_front();
          if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y
              || m_tdata[95:64] !== want.z || m_tuser[0] !== want.ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp x=%h y=%h z=%h ovf=%b, got x=%h y=%h z=%h ovf=%b",
                       want.x, want.y, want.z, want.ovf, m_tdata[31:0],
                       m_tdata[63:32], m_tdata[95:64], m_tuser[0]);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fork
      begin
        repeat (6) @(posedge clk);
        rst <= 1'b0;

        // identity transform out of reset
        @(negedge clk);
        add_vertex(32'h0, 32'h0, 32'h0, 1'b1);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 1'b1);

        // scale saturation in both directions, half-ulp rounding on z
        reg_writes.push_back({REG_SCALE_X, 64'h0000_0000_7FFF_FFFF});
        reg_writes.push_back({REG_SCALE_Y, 64'h0000_0000_8000_0000});
        reg_writes.push_back({REG_SCALE_Z, 64'h0000_0000_0000_8000});
        reg_writes.push_back({REG_POS_X, 64'h0000_0000_8000_0000});
        reg_writes.push_back({REG_POS_Y, 64'h0000_0000_7FFF_FFFF});
        reg_writes.push_back({REG_POS_Z, 64'h0000_0000_0000_0001});
        program_regs();
        @(negedge clk);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_vertex(32'h0, 32'h0, 32'h0000_0003, 1'b1);
        add_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0);
        add_vertex(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1);

        // non-unit quaternion at the component limits; unmapped index ignored
        reg_writes.push_back({REG_SCALE_X, 64'h0000_0000_0001_0000});
        reg_writes.push_back({REG_SCALE_Y, 64'h0000_0000_0001_0000});
        reg_writes.push_back({REG_SCALE_Z, 64'h0000_0000_0001_0000});
        reg_writes.push_back({REG_POS_X, 64'h0});
        reg_writes.push_back({REG_POS_Y, 64'h0});
        reg_writes.push_back({REG_POS_Z, 64'h0});
        reg_writes.push_back({REG_ROT, 64'h8000_7FFF_8000_7FFF});
        reg_writes.push_back({RegUnmapped, 64'hFFFF_FFFF_FFFF_FFFF});
        program_regs();
        @(negedge clk);
        add_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b0);
        add_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b1);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_vertex(32'h0000_0003, 32'hFFFF_FFFB, 32'h0000_0007, 1'b0);

        // 90 degrees about z, mirrored x, fractional y scale, flattened z
        reg_writes.push_back({REG_ROT, 64'h2D41_0000_0000_2D41});
        reg_writes.push_back({REG_SCALE_X, 64'h0000_0000_FFFF_0000});
        reg_writes.push_back({REG_SCALE_Y, 64'h0000_0000_0001_8000});
        reg_writes.push_back({REG_SCALE_Z, 64'h0});
        reg_writes.push_back({REG_POS_X, 64'h0000_0000_0001_0000});
        reg_writes.push_back({REG_POS_Y, 64'h0000_0000_FFFE_0000});
        reg_writes.push_back({REG_POS_Z, 64'h0000_0000_7FFF_FFFF});
        program_regs();
        @(negedge clk);
        add_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b1);
        add_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b1);
        add_vertex(32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_FFFF, 1'b1);
        add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);

        for (int ph = 0; ph < RandPhases; ph++) begin
          queue_transform(ph % 3);
          program_regs();
          case (ph % 4)
            0: begin
              send_idle_pct  <= 0;
              recv_stall_pct <= 0;
            end
            1: begin
              send_idle_pct  <= 67;
              recv_stall_pct <= 0;
            end
            2: begin
              send_idle_pct  <= 0;
              recv_stall_pct <= 67;
            end
            default: begin
              send_idle_pct  <= 32;
              recv_stall_pct <= 32;
            end
          endcase
          @(negedge clk);
          for (int n = 0; n < PhaseItems; n++)
            vertex_queue.push_back({rand_coord(), rand_coord(), rand_coord(),
                                    1'($urandom_range(1)),
                                    1'($urandom_range(99) == 0)});
        end

        wait_idle();
        repeat (16) @(posedge clk);
      end
      begin
        while (quiet_cycles < WatchdogLimit) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatch_count == 0 && predicted_vertices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vqt_pkg.sv
hw/rtl/vertex_quaternion_transform.sv
hw/rtl/vqt_checker.sv
verif/testbench.sv
